[sv/pctdec_pkg.sv]
`timescale 1ns / 1ps
// Package for the strict percent decoder: mode codes, character constants,
// result word type and character classification functions. No dependencies.
package pctdec_pkg;

  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_PERCENT = 2'd1;
  localparam logic [1:0] MODE_ONE_HEX = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_DOT        = 8'h2e;
  localparam logic [7:0] CHAR_TILDE      = 8'h7e;
  localparam logic [7:0] CHAR_DASH       = 8'h2d;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CHAR_SLASH      = 8'h2f;
  localparam logic [7:0] HEX_ALPHA_BASE  = 8'd10;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       string_end;
    logic       bad_string;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] ch);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (ch >= "0" && ch <= "9") begin
      d = ch - 8'("0");
      h.ok = 1'b1;
    end else if (ch >= "a" && ch <= "f") begin
      d = ch - 8'("a") + HEX_ALPHA_BASE;
      h.ok = 1'b1;
    end else if (ch >= "A" && ch <= "F") begin
      d = ch - 8'("A") + HEX_ALPHA_BASE;
      h.ok = 1'b1;
    end
    h.nibble = d[3:0];
    return h;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "z") ||
           (ch >= "A" && ch <= "Z") || ch == CHAR_DOT || ch == CHAR_TILDE ||
           ch == CHAR_DASH || ch == CHAR_UNDERSCORE || ch == CHAR_SLASH;
  endfunction

endpackage

[sv/pctdec_core.sv]
`timescale 1ns / 1ps
// Decode state (mode, high nibble) and the per-byte decode logic.
// Depends on pctdec_pkg.
module pctdec_core import pctdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output result_t    res
);

  logic [1:0] mode;
  logic [1:0] mode_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  hex_t       hv;

  always_comb begin
    hv = hex_value(in_byte);
    res = '0;
    mode_next = mode;
    high_nibble_next = high_nibble;
    unique case (mode)
      MODE_NORMAL: begin
        if (in_byte == CHAR_PERCENT) begin
          mode_next = MODE_PERCENT;
        end else if (is_unreserved(in_byte)) begin
          res.out_valid = 1'b1;
          res.out_byte = in_byte;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_PERCENT: begin
        if (hv.ok) begin
          high_nibble_next = hv.nibble;
          mode_next = MODE_ONE_HEX;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_ONE_HEX: begin
        if (hv.ok) begin
          res.out_valid = 1'b1;
          res.out_byte = {high_nibble, hv.nibble};
          mode_next = MODE_NORMAL;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      default: begin
        mode_next = MODE_ERROR;
      end
    endcase
    res.string_end = last_byte;
    if (last_byte) begin
      res.bad_string = (mode_next != MODE_NORMAL);
      mode_next = MODE_NORMAL;
      high_nibble_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      high_nibble <= '0;
    end else if (load) begin
      mode <= mode_next;
      high_nibble <= high_nibble_next;
    end
  end

endmodule

[sv/pctdec_skid.sv]
`timescale 1ns / 1ps
// Output register plus one skid entry for the result word.
// Depends on pctdec_pkg.
module pctdec_skid import pctdec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop = res_valid && res_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && res_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res_data <= skid_data;
      end
    end else if (push && res_valid && !pop) begin
      skid_data <= push_data;
    end else if (push) begin
      res_data <= push_data;
    end
  end

endmodule

[sv/strict_percent_decoder.sv]
`timescale 1ns / 1ps
// Strict URI percent decoder, one byte word in and one result word out.
// The result is registered in the output register, or the skid entry if stalled.
// 1 word per cycle unless stalled; a two-entry output stage absorbs one stall.
// Reset (rst, synchronous): mode normal, nibble zero, output stage empty.
// Depends on pctdec_pkg, pctdec_core, pctdec_skid.
module strict_percent_decoder import pctdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       string_end,
  output logic       bad_string
);

  logic    accept;
  result_t core_res;
  result_t res_data;

  assign accept = in_valid && in_ready;

  pctdec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .res       (core_res)
  );

  pctdec_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_res),
    .space     (in_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign out_valid  = res_data.out_valid;
  assign out_byte   = res_data.out_byte;
  assign string_end = res_data.string_end;
  assign bad_string = res_data.bad_string;

endmodule

[sv/pctdec_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for strict_percent_decoder, attached by bind.
// Depends on strict_percent_decoder ports only.
module pctdec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       out_valid,
  input logic [7:0] out_byte,
  input logic       string_end,
  input logic       bad_string
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_valid) && $stable(out_byte) &&
      $stable(string_end) && $stable(bad_string))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid && in_ready)
    else $error("output stage not empty after reset");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_byte == 8'd0)
    else $error("out_byte nonzero without out_valid");

  a_bad_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_string |-> string_end && !out_valid)
    else $error("bad_string outside string end or with a byte");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> res_valid)
    else $error("input stalled with empty output");

endmodule

bind strict_percent_decoder pctdec_checker u_pctdec_checker (.*);
